FILE: src/interarrival_space_saving_tracker_defines.svh
// ----------------------------------------------------------------------------
// interarrival space-saving tracker assertion macros
// shared concurrent check forms for the tracker modules
// ----------------------------------------------------------------------------
`ifndef INTERARRIVAL_SPACE_SAVING_TRACKER_DEFINES_SVH
`define INTERARRIVAL_SPACE_SAVING_TRACKER_DEFINES_SVH

// property that holds on every clock outside reset
`define ISS_ASSERT_HOLD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// types and constants shared by the tracker controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package iss_pkg;

    localparam int INTERVAL_BITS = 31;
    localparam int KEY_PORT_BITS = 64;

    localparam logic [INTERVAL_BITS-1:0] EMPTY_MARK   = 31'h7FFF_FFFF;
    localparam logic [INTERVAL_BITS-1:0] ONCE_MARK    = 31'h7FFF_FFFE;
    localparam logic [INTERVAL_BITS-1:0] SAT_INTERVAL = 31'h7FFF_FFFD;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_QUERY   = 1'b1;

    typedef logic [INTERVAL_BITS-1:0] interval_t;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic scan_step;
        logic decide;
        logic sink_rd_l;
        logic sink_latch_l;
        logic sink_step;
        logic rise_rd;
        logic rise_step;
        logic place;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic is_query;
        logic hit;
        logic grow;
        logic has_left;
        logic at_root;
        logic go_down;
        logic go_up;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: src/iss_stream_if.sv
// ----------------------------------------------------------------------------
// iss stream interfaces
// request and result channels of the tracker, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface iss_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [iss_pkg::KEY_PORT_BITS-1:0]   item_key;

    modport source (output valid, output opcode, output item_key, input ready);
    modport sink   (input valid, input opcode, input item_key, output ready);
endinterface

interface iss_out_if;
    logic                                valid;
    logic                                ready;
    logic                                was_tracked;
    iss_pkg::interval_t                  interval;
    logic                                evicted_valid;
    logic [iss_pkg::KEY_PORT_BITS-1:0]   evicted_key;
    logic                                no_answer;

    modport source (output valid, output was_tracked, output interval,
                    output evicted_valid, output evicted_key, output no_answer,
                    input ready);
    modport sink   (input valid, input was_tracked, input interval,
                    input evicted_valid, input evicted_key, input no_answer,
                    output ready);
endinterface

`default_nettype wire

FILE: src/iss_ctrl.sv
// ----------------------------------------------------------------------------
// iss_ctrl
// sequencer for clear, key scan, decision and heap sift
// ----------------------------------------------------------------------------
`default_nettype none

`include "interarrival_space_saving_tracker_defines.svh"

module iss_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire iss_pkg::dp_status_t status,
    output iss_pkg::dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SINK_CHK,
        S_SINK_L,
        S_SINK_R,
        S_RISE_CHK,
        S_RISE_CMP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (status.is_query)
                begin
                    state_next = S_DONE;
                end
                else if (status.hit && status.grow)
                begin
                    state_next = S_RISE_CHK;
                end
                else
                begin
                    state_next = S_SINK_CHK;
                end
            end
            S_SINK_CHK:
            begin
                if (status.has_left)
                begin
                    cmd.sink_rd_l = 1'b1;
                    state_next    = S_SINK_L;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SINK_L:
            begin
                cmd.sink_latch_l = 1'b1;
                state_next       = S_SINK_R;
            end
            S_SINK_R:
            begin
                cmd.sink_step = 1'b1;
                state_next    = status.go_down ? S_SINK_CHK : S_DONE;
            end
            S_RISE_CHK:
            begin
                if (status.at_root)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rise_rd = 1'b1;
                    state_next  = S_RISE_CMP;
                end
            end
            S_RISE_CMP:
            begin
                cmd.rise_step = 1'b1;
                state_next    = status.go_up ? S_RISE_CHK : S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = ready_reg;

    `ISS_ASSERT_NEXT(a_done_to_idle, (state_reg == S_DONE) && status.out_free, state_reg == S_IDLE, "result not handed off")
    `ISS_ASSERT_NEXT(a_scan_to_decide, (state_reg == S_SCAN) && status.scan_done, state_reg == S_DECIDE, "scan end missed")
    `ISS_ASSERT_HOLD(a_ready_idle, !ready_reg || (state_reg == S_IDLE), "ready outside idle")

endmodule

`default_nettype wire

FILE: src/iss_dp.sv
// ----------------------------------------------------------------------------
// iss_dp
// heap memory, key scan, interval arithmetic, sift datapath and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "interarrival_space_saving_tracker_defines.svh"

module iss_dp #(
    parameter int CAPACITY  = 64,
    parameter int KEY_BITS  = 64,
    parameter int TIME_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire iss_pkg::dp_cmd_t                  cmd,
    output iss_pkg::dp_status_t                    status,
    input  wire logic                              opcode,
    input  wire logic [iss_pkg::KEY_PORT_BITS-1:0] item_key,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   was_tracked,
    output iss_pkg::interval_t                     interval,
    output logic                                   evicted_valid,
    output logic [iss_pkg::KEY_PORT_BITS-1:0]      evicted_key,
    output logic                                   no_answer
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // heap memory, one row per slot
    iss_pkg::interval_t   mem_int  [CAPACITY];
    logic [KEY_BITS-1:0]  mem_key  [CAPACITY];
    logic [TIME_BITS-1:0] mem_time [CAPACITY];
    logic                 mem_vld  [CAPACITY];

    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    iss_pkg::interval_t   wr_int;
    logic [KEY_BITS-1:0]  wr_key;
    logic [TIME_BITS-1:0] wr_time;
    logic                 wr_vld;
    logic [IW-1:0]        rd_addr;

    iss_pkg::interval_t   rd_int_reg;
    logic [KEY_BITS-1:0]  rd_key_reg;
    logic [TIME_BITS-1:0] rd_time_reg;
    logic                 rd_vld_reg;

    // request and scan state
    logic                 op_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [TIME_BITS-1:0] tick_reg;
    logic [CW-1:0]        scan_idx_reg;
    logic                 dv_reg;
    logic [IW-1:0]        didx_reg;
    logic                 hit_reg;
    logic [IW-1:0]        hpos_reg;
    iss_pkg::interval_t   hint_reg;
    logic [TIME_BITS-1:0] htime_reg;
    logic                 fno_reg;
    iss_pkg::interval_t   fno_int_reg;
    logic                 root_vld_reg;
    logic [KEY_BITS-1:0]  root_key_reg;
    iss_pkg::interval_t   root_int_reg;

    // entry being placed and its hole position
    iss_pkg::interval_t   cur_int_reg;
    logic [KEY_BITS-1:0]  cur_key_reg;
    logic [TIME_BITS-1:0] cur_time_reg;
    logic [IW-1:0]        pos_reg;

    iss_pkg::interval_t   l_int_reg;
    logic [KEY_BITS-1:0]  l_key_reg;
    logic [TIME_BITS-1:0] l_time_reg;
    logic                 l_vld_reg;

    // pending result and output register
    logic                 res_tracked_reg;
    iss_pkg::interval_t   res_int_reg;
    logic                 res_ev_vld_reg;
    logic [KEY_BITS-1:0]  res_ev_key_reg;
    logic                 res_none_reg;
    logic                 out_valid_reg;
    logic                 out_tracked_reg;
    iss_pkg::interval_t   out_int_reg;
    logic                 out_ev_vld_reg;
    logic [KEY_BITS-1:0]  out_ev_key_reg;
    logic                 out_none_reg;

    // combinational helpers
    logic                 scan_in_range;
    logic [IW:0]          l_idx;
    logic [IW:0]          r_idx;
    logic [IW-1:0]        parent_idx;
    logic                 has_left;
    logic                 has_right;
    logic                 use_r;
    iss_pkg::interval_t   big_int;
    logic [KEY_BITS-1:0]  big_key;
    logic [TIME_BITS-1:0] big_time;
    logic                 big_vld;
    logic [IW-1:0]        big_idx;
    logic                 go_down;
    logic                 go_up;
    logic [TIME_BITS-1:0] diff;
    logic [31:0]          diff_ext;
    iss_pkg::interval_t   nv;
    logic                 grow;
    logic                 scan_hit;

    assign scan_in_range = (scan_idx_reg < CW'(CAPACITY));
    assign l_idx         = {pos_reg, 1'b1};
    assign r_idx         = l_idx + (IW + 1)'(1);
    assign parent_idx    = IW'((pos_reg - IW'(1)) >> 1);
    assign has_left      = (l_idx < (IW + 1)'(CAPACITY));
    assign has_right     = (r_idx < (IW + 1)'(CAPACITY));

    // larger child, right wins a tie
    assign use_r    = has_right && (l_int_reg <= rd_int_reg);
    assign big_int  = use_r ? rd_int_reg  : l_int_reg;
    assign big_key  = use_r ? rd_key_reg  : l_key_reg;
    assign big_time = use_r ? rd_time_reg : l_time_reg;
    assign big_vld  = use_r ? rd_vld_reg  : l_vld_reg;
    assign big_idx  = use_r ? r_idx[IW-1:0] : l_idx[IW-1:0];
    assign go_down  = (cur_int_reg < big_int);
    assign go_up    = (rd_int_reg < cur_int_reg);

    // ticks since previous arrival, saturated below the marks
    assign diff     = tick_reg - htime_reg;
    assign diff_ext = 32'(diff);
    assign nv       = (diff_ext > 32'(iss_pkg::SAT_INTERVAL)) ? iss_pkg::SAT_INTERVAL
                                                              : iss_pkg::INTERVAL_BITS'(diff_ext);
    assign grow     = (nv > hint_reg);
    assign scan_hit = dv_reg && rd_vld_reg && (rd_key_reg == key_reg) && !hit_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_int  = cur_int_reg;
        wr_key  = cur_key_reg;
        wr_time = cur_time_reg;
        wr_vld  = 1'b1;
        rd_addr = '0;
        if (cmd.clr_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = scan_idx_reg[IW-1:0];
            wr_int  = iss_pkg::EMPTY_MARK;
            wr_vld  = 1'b0;
        end
        if (cmd.place)
        begin
            wr_en = 1'b1;
        end
        if (cmd.sink_step)
        begin
            wr_en = 1'b1;
            if (go_down)
            begin
                wr_int  = big_int;
                wr_key  = big_key;
                wr_time = big_time;
                wr_vld  = big_vld;
            end
        end
        if (cmd.rise_step)
        begin
            wr_en = 1'b1;
            if (go_up)
            begin
                wr_int  = rd_int_reg;
                wr_key  = rd_key_reg;
                wr_time = rd_time_reg;
                wr_vld  = rd_vld_reg;
            end
        end
        if (cmd.scan_step && scan_in_range)
        begin
            rd_addr = scan_idx_reg[IW-1:0];
        end
        if (cmd.sink_rd_l)
        begin
            rd_addr = l_idx[IW-1:0];
        end
        if (cmd.sink_latch_l)
        begin
            rd_addr = has_right ? r_idx[IW-1:0] : l_idx[IW-1:0];
        end
        if (cmd.rise_rd)
        begin
            rd_addr = parent_idx;
        end
    end

    // heap memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_int[wr_addr]  <= wr_int;
            mem_key[wr_addr]  <= wr_key;
            mem_time[wr_addr] <= wr_time;
            mem_vld[wr_addr]  <= wr_vld;
        end
        rd_int_reg  <= mem_int[rd_addr];
        rd_key_reg  <= mem_key[rd_addr];
        rd_time_reg <= mem_time[rd_addr];
        rd_vld_reg  <= mem_vld[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            scan_idx_reg  <= '0;
            dv_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            fno_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dv_reg <= 1'b0;
            if (cmd.clr_wr)
            begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
            if (cmd.accept)
            begin
                tick_reg     <= tick_reg + TIME_BITS'(1);
                scan_idx_reg <= '0;
                hit_reg      <= 1'b0;
                fno_reg      <= 1'b0;
            end
            if (cmd.scan_step && scan_in_range)
            begin
                dv_reg       <= 1'b1;
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
            if (scan_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (dv_reg && !fno_reg && (rd_int_reg != iss_pkg::ONCE_MARK))
            begin
                fno_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= opcode;
            key_reg <= item_key[KEY_BITS-1:0];
        end
        if (cmd.scan_step)
        begin
            didx_reg <= scan_idx_reg[IW-1:0];
        end
        if (scan_hit)
        begin
            hpos_reg  <= didx_reg;
            hint_reg  <= rd_int_reg;
            htime_reg <= rd_time_reg;
        end
        if (dv_reg && !fno_reg && (rd_int_reg != iss_pkg::ONCE_MARK))
        begin
            fno_int_reg <= rd_int_reg;
        end
        if (dv_reg && (didx_reg == '0))
        begin
            root_vld_reg <= rd_vld_reg;
            root_key_reg <= rd_key_reg;
            root_int_reg <= rd_int_reg;
        end
        if (cmd.decide)
        begin
            res_tracked_reg <= hit_reg;
            res_ev_vld_reg  <= 1'b0;
            res_ev_key_reg  <= '0;
            res_none_reg    <= 1'b0;
            cur_key_reg     <= key_reg;
            cur_time_reg    <= tick_reg;
            if (op_reg == iss_pkg::OP_QUERY)
            begin
                if (hit_reg)
                begin
                    res_int_reg <= hint_reg;
                end
                else
                begin
                    res_int_reg  <= fno_reg ? fno_int_reg : '0;
                    res_none_reg <= !fno_reg;
                end
            end
            else if (hit_reg)
            begin
                cur_int_reg <= nv;
                pos_reg     <= hpos_reg;
                res_int_reg <= nv;
            end
            else
            begin
                // newcomer takes over the root slot
                cur_int_reg    <= (root_int_reg == iss_pkg::EMPTY_MARK) ? iss_pkg::ONCE_MARK
                                                                        : root_int_reg;
                res_int_reg    <= (root_int_reg == iss_pkg::EMPTY_MARK) ? iss_pkg::ONCE_MARK
                                                                        : root_int_reg;
                pos_reg        <= '0;
                res_ev_vld_reg <= root_vld_reg;
                res_ev_key_reg <= root_vld_reg ? root_key_reg : '0;
            end
        end
        if (cmd.sink_latch_l)
        begin
            l_int_reg  <= rd_int_reg;
            l_key_reg  <= rd_key_reg;
            l_time_reg <= rd_time_reg;
            l_vld_reg  <= rd_vld_reg;
        end
        if (cmd.sink_step && go_down)
        begin
            pos_reg <= big_idx;
        end
        if (cmd.rise_step && go_up)
        begin
            pos_reg <= parent_idx;
        end
        if (cmd.out_load)
        begin
            out_tracked_reg <= res_tracked_reg;
            out_int_reg     <= res_int_reg;
            out_ev_vld_reg  <= res_ev_vld_reg;
            out_ev_key_reg  <= res_ev_key_reg;
            out_none_reg    <= res_none_reg;
        end
    end

    always_comb
    begin
        status           = '0;
        status.clr_last  = (scan_idx_reg == CW'(CAPACITY - 1));
        status.scan_done = !scan_in_range && !dv_reg;
        status.is_query  = (op_reg == iss_pkg::OP_QUERY);
        status.hit       = hit_reg;
        status.grow      = grow;
        status.has_left  = has_left;
        status.at_root   = (pos_reg == '0);
        status.go_down   = go_down;
        status.go_up     = go_up;
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign was_tracked   = out_tracked_reg;
    assign interval      = out_int_reg;
    assign evicted_valid = out_ev_vld_reg;
    assign evicted_key   = iss_pkg::KEY_PORT_BITS'(out_ev_key_reg);
    assign no_answer     = out_none_reg;

    `ISS_ASSERT_NEXT(a_hit_kept, hit_reg && !cmd.accept, hit_reg, "hit flag lost during request")
    `ISS_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_reg, "result not presented")
    `ISS_ASSERT_HOLD(a_one_write, !(cmd.sink_step && cmd.rise_step), "two heap writes at once")

endmodule

`default_nettype wire

FILE: src/interarrival_space_saving_tracker.sv
// ----------------------------------------------------------------------------
// interarrival_space_saving_tracker
// space-saving tracker of keys ordered by inter-arrival interval
// ----------------------------------------------------------------------------
// After reset the block clears every heap slot and holds request.ready low.
// For each request the key lookup walks every heap slot through the single
// read port of the heap memory, one slot per cycle, and each sink level needs
// two child reads and one write. One request is worked at a time; a finished
// result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module interarrival_space_saving_tracker #(
    parameter int CAPACITY  = 64,
    parameter int KEY_BITS  = 64,
    parameter int TIME_BITS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    iss_in_if.sink     request,
    iss_out_if.source  result
);

    // command and status between sequencer and datapath
    iss_pkg::dp_cmd_t    cmd;
    iss_pkg::dp_status_t status;

    // sequencer: clear pass, scan, decision, sift, hand-off
    iss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // heap memory with lookup, interval math and result register
    iss_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_BITS  (KEY_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (request.opcode),
        .item_key      (request.item_key),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .was_tracked   (result.was_tracked),
        .interval      (result.interval),
        .evicted_valid (result.evicted_valid),
        .evicted_key   (result.evicted_key),
        .no_answer     (result.no_answer)
    );

endmodule

`default_nettype wire
